// File: hw/rtl/mpwm_pkg.sv
// Shared types and constants for the multichannel PWM port generator.
// Used by the per-pin lane and the top level; depends on nothing else.
package mpwm_pkg;

   localparam int PORT_WIDTH      = 32;
   localparam int FIELD_TICK_BITS = 16;
   localparam int PIN_INDEX_BITS  = 5;
   localparam int PIN_COUNT_DEF   = 32;
   localparam int TICK_WIDTH_DEF  = 16;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_SET    = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   typedef struct packed {
      command_type                command;
      logic [PIN_INDEX_BITS-1:0]  pin;
      logic                       level;
      logic [FIELD_TICK_BITS-1:0] duty_ticks;
      logic [FIELD_TICK_BITS-1:0] period_ticks;
   } req_type;

   typedef struct packed {
      logic [PORT_WIDTH-1:0] port_word;
      logic                  sample_valid;
   } rsp_type;

   // Per-pin controls decoded from one accepted transaction.
   typedef struct packed {
      logic tick;
      logic write;
      logic load;
      logic level;
   } lane_ctrl_type;

endpackage

// File: hw/rtl/mpwm_lane.sv
// One PWM pin: duty, period, countdown and the pin's port bit.
// Depends on mpwm_pkg for the lane control struct.
module mpwm_lane import mpwm_pkg::*; #(
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  lane_ctrl_type         ctrl,
   input  logic [TICK_WIDTH-1:0] duty,
   input  logic [TICK_WIDTH-1:0] period,
   output logic                  bit_next
);

   logic [TICK_WIDTH-1:0] duty_ff, duty_in;
   logic [TICK_WIDTH-1:0] period_ff, period_in;
   logic [TICK_WIDTH-1:0] count_ff, count_in;
   logic                  bit_ff, bit_in;

   always_comb begin
      duty_in   = duty_ff;
      period_in = period_ff;
      count_in  = count_ff;
      bit_in    = bit_ff;
      if (ctrl.tick && (duty_ff != '0)) begin
         if (count_ff == '0) begin
            bit_in = ~bit_ff;
            if (bit_ff) begin
               // Falling edge: low time is what the period leaves after the duty.
               count_in = (period_ff > duty_ff) ? (period_ff - duty_ff) : '0;
            end else begin
               count_in = duty_ff;
            end
         end else begin
            count_in = count_ff - 1'b1;
         end
      end else if (ctrl.write) begin
         bit_in = ctrl.level;
      end else if (ctrl.load) begin
         duty_in   = duty;
         period_in = period;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff   <= '0;
         period_ff <= '0;
         count_ff  <= '0;
         bit_ff    <= 1'b0;
      end else if (enable) begin
         duty_ff   <= duty_in;
         period_ff <= period_in;
         count_ff  <= count_in;
         bit_ff    <= bit_in;
      end
   end

   assign bit_next = bit_in;

endmodule

// File: hw/rtl/multichannel_pwm_port_generator_unit.sv
// Top level of the multichannel PWM port generator: pin lanes and result skid.
// Depends on mpwm_pkg and mpwm_lane.
//
// Usage: each request transaction on req_ carries one command. A tick
// advances every pin whose duty is non-zero and returns the port word as a
// sample; a write sets one pin bit; a set-channel loads a pin's duty and
// period and clears its countdown. Every request yields exactly one response
// on rsp_, with sample_valid high only for ticks.
// An accepted response goes to the output register, or to the skid register
// while the output is held. Throughput is one transaction per cycle while the
// skid entry is empty, set by the per-pin lanes, which update in parallel on acceptance.
// When the receiver stalls, a one-entry skid register takes the next
// transaction, and req_stall rises only while that skid entry is full.
// Synchronous reset clears the port word, all duty, period and countdown
// values, and empties both output registers.
module multichannel_pwm_port_generator_unit import mpwm_pkg::*; #(
   parameter int PIN_COUNT  = PIN_COUNT_DEF,
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                          accept;
   logic                          rsp_fire;
   logic [PORT_WIDTH-1:0]         port_next;
   rsp_type                       result;
   logic [TICK_WIDTH+FIELD_TICK_BITS-1:0] duty_wide, period_wide;
   logic [TICK_WIDTH-1:0]         duty_fit, period_fit;

   rsp_type main_ff, main_in;
   logic    main_valid_ff, main_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_fire  = main_valid_ff && !rsp_stall;

   // Fit the 16-bit fields to the lane width: truncate or zero-extend.
   assign duty_wide   = {{TICK_WIDTH{1'b0}}, req_data.duty_ticks};
   assign period_wide = {{TICK_WIDTH{1'b0}}, req_data.period_ticks};
   assign duty_fit    = duty_wide[TICK_WIDTH-1:0];
   assign period_fit  = period_wide[TICK_WIDTH-1:0];

   genvar p;
   generate
      for (p = 0; p < PORT_WIDTH; p++) begin : g_pin
         if (p < PIN_COUNT) begin : g_lane
            lane_ctrl_type ctrl;
            logic          selected;
            assign selected   = (req_data.pin == PIN_INDEX_BITS'(p));
            assign ctrl.tick  = (req_data.command == CMD_TICK);
            assign ctrl.write = (req_data.command == CMD_WRITE) && selected;
            assign ctrl.load  = (req_data.command == CMD_SET) && selected;
            assign ctrl.level = req_data.level;

            mpwm_lane #(
               .TICK_WIDTH (TICK_WIDTH)
            ) u_lane (
               .clock    (clock),
               .reset    (reset),
               .enable   (accept),
               .ctrl     (ctrl),
               .duty     (duty_fit),
               .period   (period_fit),
               .bit_next (port_next[p])
            );
         end else begin : g_unused
            assign port_next[p] = 1'b0;
         end
      end
   endgenerate

   assign result.port_word    = port_next;
   assign result.sample_valid = (req_data.command == CMD_TICK);

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // The skid entry is only ever filled behind a held output entry.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid while output register empty");

   // A transaction accepted into an empty output shows up next cycle with its kind.
   a_accept_to_output: assert property (@(posedge clock) disable iff (reset)
      (accept && !main_valid_ff) |=>
         (rsp_valid && (rsp_data.sample_valid == $past(req_data.command == CMD_TICK))))
      else $error("accepted transaction did not reach the output register");

   // A stalled receiver never causes the skid entry to be dropped.
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(skid_ff)))
      else $error("skid entry lost under stall");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_pwm_port_generator_unit: a port model
// predicts every response. Depends on mpwm_pkg and the unit's RTL only.

module tb;
   import mpwm_pkg::*;

   localparam int PINS          = 32;
   localparam int WATCHDOG_IDLE = 1000;
   localparam int DRAIN_CYCLES  = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Port model state.
   logic [PINS-1:0] model_port;
   logic [15:0]     model_duty   [PINS];
   logic [15:0]     model_period [PINS];
   logic [15:0]     model_count  [PINS];

   rsp_type expected_ports[$];
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   int      stall_cycles   = 0;
   bit      sender_gaps    = 1'b0;
   bit      receiver_stalls = 1'b0;

   multichannel_pwm_port_generator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic port_model_clear();
      model_port = '0;
      for (int p = 0; p < PINS; p++) begin
         model_duty[p]   = '0;
         model_period[p] = '0;
         model_count[p]  = '0;
      end
   endtask

   task automatic port_model_step(input req_type item, output rsp_type res);
      case (item.command)
         CMD_TICK: begin
            for (int p = 0; p < PINS; p++) begin
               if (model_duty[p] != 0) begin
                  if (model_count[p] == 0) begin
                     if (model_port[p]) begin
                        model_port[p]  = 1'b0;
                        model_count[p] = (model_period[p] > model_duty[p]) ?
                                         model_period[p] - model_duty[p] : 16'd0;
                     end else begin
                        model_port[p]  = 1'b1;
                        model_count[p] = model_duty[p];
                     end
                  end else begin
                     model_count[p] = model_count[p] - 16'd1;
                  end
               end
            end
         end
         CMD_WRITE: begin
            model_port[item.pin] = item.level;
         end
         CMD_SET: begin
            model_duty[item.pin]   = item.duty_ticks;
            model_period[item.pin] = item.period_ticks;
            model_count[item.pin]  = '0;
         end
         default: ;
      endcase
      res.port_word    = model_port;
      res.sample_valid = (item.command == CMD_TICK);
   endtask

   function automatic req_type make_item(command_type cmd, int pin, int level,
                                         int duty, int period);
      req_type item;
      item.command      = cmd;
      item.pin          = PIN_INDEX_BITS'(pin);
      item.level        = 1'(level);
      item.duty_ticks   = FIELD_TICK_BITS'(duty);
      item.period_ticks = FIELD_TICK_BITS'(period);
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int r;
      r = $urandom_range(0, 99);
      item.command = (r < 55) ? CMD_TICK : (r < 75) ? CMD_SET :
                     (r < 93) ? CMD_WRITE : CMD_UNUSED;
      item.pin   = PIN_INDEX_BITS'($urandom_range(0, PINS - 1));
      item.level = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 70) begin
         item.duty_ticks   = FIELD_TICK_BITS'($urandom_range(0, 6));
         item.period_ticks = FIELD_TICK_BITS'($urandom_range(0, 12));
      end else if (r < 85) begin
         item.period_ticks = FIELD_TICK_BITS'($urandom_range(0, 4));
         item.duty_ticks   = FIELD_TICK_BITS'($urandom_range(3, 9));
      end else begin
         item.duty_ticks   = FIELD_TICK_BITS'($urandom_range(0, 16'hFFFF));
         item.period_ticks = FIELD_TICK_BITS'($urandom_range(0, 16'hFFFF));
      end
      return item;
   endfunction

   // Presents one request and waits for the transaction; the expected
   // response is recorded at the accepting edge.
   task automatic send_item(input req_type item);
      int      gap;
      rsp_type res;
      gap = sender_gaps ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      port_model_step(item, res);
      expected_ports.push_back(res);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_ports.size() != 0);
   endtask

   // A few channels with short duty and period, then a run of ticks with
   // occasional direct writes.
   task automatic pwm_burst();
      int channels;
      int ticks;
      channels = $urandom_range(1, 8);
      for (int c = 0; c < channels; c++)
         send_item(make_item(CMD_SET, $urandom_range(0, PINS - 1), $urandom_range(0, 1),
                             $urandom_range(1, 5), $urandom_range(0, 10)));
      ticks = $urandom_range(15, 35);
      for (int t = 0; t < ticks; t++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(make_item(CMD_WRITE, $urandom_range(0, PINS - 1),
                                $urandom_range(0, 1), $urandom, $urandom));
         else
            send_item(make_item(CMD_TICK, $urandom_range(0, PINS - 1),
                                $urandom_range(0, 1), $urandom, $urandom));
      end
   endtask

   task automatic test_directed();
      send_item(make_item(CMD_TICK,   0, 0, 0, 0));
      send_item(make_item(CMD_WRITE,  0, 1, 0, 0));
      send_item(make_item(CMD_WRITE, 31, 1, 16'hFFFF, 16'hFFFF));
      send_item(make_item(CMD_WRITE, 31, 0, 0, 0));
      send_item(make_item(CMD_WRITE,  0, 0, 0, 0));
      send_item(make_item(CMD_UNUSED, 31, 1, 16'hFFFF, 16'hFFFF));
      send_item(make_item(CMD_SET,    0, 1, 1, 2));
      repeat (5) send_item(make_item(CMD_TICK, 0, 0, 0, 0));
      // Duty above period: the low phase reload saturates at zero.
      send_item(make_item(CMD_SET,   31, 0, 3, 1));
      repeat (5) send_item(make_item(CMD_TICK, 31, 1, 16'hFFFF, 16'hFFFF));
      send_item(make_item(CMD_SET,    7, 1, 16'hFFFF, 16'hFFFF));
      repeat (2) send_item(make_item(CMD_TICK, 7, 0, 0, 0));
      // A write on a running pin only changes the bit, not the countdown.
      send_item(make_item(CMD_WRITE,  0, 1, 0, 0));
      send_item(make_item(CMD_TICK,   0, 0, 0, 0));
      send_item(make_item(CMD_SET,    0, 0, 0, 5));
      send_item(make_item(CMD_TICK,   0, 0, 0, 0));
   endtask

   task automatic test_pwm_bursts();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      repeat (10) pwm_burst();
   endtask

   task automatic test_drain_pause();
      receiver_stalls = 1'b1;
      repeat (10) send_item(random_item());
      wait_until_drained();
      repeat (10) send_item(random_item());
   endtask

   task automatic test_random_traffic();
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      for (int n = 0; n < 30; n++) begin
         if (n % 2 == 0)
            pwm_burst();
         else
            repeat (30) send_item(random_item());
         // Stretches with no idling on either side.
         if (n == 10 || n == 20) begin
            sender_gaps     = !sender_gaps;
            receiver_stalls = !receiver_stalls;
         end
      end
   endtask

   initial begin
      port_model_clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pwm_bursts();
      test_drain_pause();
      test_random_traffic();
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      int n;
      if (reset || !receiver_stalls) begin
         rsp_stall <= 1'b0;
         stall_cycles = 0;
      end else if (stall_cycles > 0) begin
         rsp_stall <= 1'b1;
         stall_cycles = stall_cycles - 1;
      end else begin
         n = idle_length();
         rsp_stall <= (n > 0);
         stall_cycles = (n > 0) ? n - 1 : 0;
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ports.size() == 0) begin
            note_mismatch("unexpected response port_word", '0, rsp_data.port_word);
         end else begin
            want = expected_ports.pop_front();
            if (rsp_data.port_word !== want.port_word)
               note_mismatch("port_word", want.port_word, rsp_data.port_word);
            if (rsp_data.sample_valid !== want.sample_valid)
               note_mismatch("sample_valid", 32'(want.sample_valid),
                             32'(rsp_data.sample_valid));
         end
      end
   end

   // Ends the run if no transaction completes on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_IDLE) begin
         $display("%0t: timeout, no transaction for %0d cycles", $realtime, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
